@@ design/vvzp_pkg.sv @@
// ----------------------------------------------------------------------------
// vvzp_pkg
// Types and constants shared by the viewport zoom and pan block.
// ----------------------------------------------------------------------------
package vvzp_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DIM_W     = 14;
   localparam logic [DIM_W-1:0] MAX_DIM = 14'd8192;

   localparam logic [11:0] ZOOM_ONE = 12'd256;
   localparam logic [11:0] ZOOM_LO  = 12'd128;
   localparam logic [11:0] ZOOM_HI  = 12'd2560;

   // bit-serial unit
   localparam int UNIT_W   = 64;
   localparam int DIV_BITS = 56;
   localparam int CNT_W    = 6;

   localparam logic [1:0] MODE_STRETCH = 2'd0;
   localparam logic [1:0] MODE_FILL    = 2'd1;

   localparam logic [2:0] OP_SET_ZOOM   = 3'd0;
   localparam logic [2:0] OP_ZOOM_POINT = 3'd1;
   localparam logic [2:0] OP_SET_PAN    = 3'd2;
   localparam logic [2:0] OP_RESET_VIEW = 3'd3;

   localparam logic [2:0] REG_SCALE_MODE    = 3'd0;
   localparam logic [2:0] REG_VIDEO_WIDTH   = 3'd1;
   localparam logic [2:0] REG_VIDEO_HEIGHT  = 3'd2;
   localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
   localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BASE,
      ST_BASE_WR,
      ST_OPS,
      ST_RUN,
      ST_CL_MW,
      ST_CL_MH,
      ST_CL_ZH,
      ST_CL_DO,
      ST_ZA_OH,
      ST_ZA_NW,
      ST_ZA_NH,
      ST_ZA_RX,
      ST_ZA_MX,
      ST_ZA_SX,
      ST_ZA_MY,
      ST_ZA_SY,
      ST_OUT_MW,
      ST_OUT_MH,
      ST_OUT_FIN
   } state_type;

endpackage

@@ design/video_viewport_zoom_pan.sv @@
// ----------------------------------------------------------------------------
// video_viewport_zoom_pan
// Places a video frame in a display window with zoom and pan.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : register writes (index 0 scale mode, 1/2 video size, 3/4 window
//            size); always ready, write to scale mode clears the pan.
//   req_*  : one event per request; tuser carries the opcode, tdata the zoom
//            request and the point.
//   rsp_*  : one viewport result per request, held in an output register.
// Sequencing: one request is worked through by a single bit-serial unit that
//   does both shift-add multiplies and restoring divides, one bit a cycle.
//   req_tready is high only in idle, so the next request is taken at the
//   soonest in the cycle after the result is loaded.
// Reset: zoom 1.0, pan 0, stretch mode, no video, window 640 x 480.
// Stall: a finished result waits in the output register; the next request
//   may be taken meanwhile and stops at its end until the register frees.
// ----------------------------------------------------------------------------
module video_viewport_zoom_pan (
   input  logic         clock,
   input  logic         reset,
   // csr
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [13:0]  csr_data,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // opcode
   input  logic [71:0]  req_tdata,   // zoom_request[15:0], point_x[40:16], point_y[65:41]
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [207:0] rsp_tdata    // view_x[31:0], view_y[63:32], view_w[94:64],
                                     // view_h[125:95], zoom_now[137:126],
                                     // pan_now_x[169:138], pan_now_y[201:170]
);

   localparam int UW = vvzp_pkg::UNIT_W;

   vvzp_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic [1:0]  scale_mode_ff;
   logic [13:0] video_width_ff, video_height_ff, window_width_ff, window_height_ff;
   logic [11:0] zoom_ff;
   logic [31:0] pan_x_ff, pan_y_ff;
   logic        rsp_valid_ff;
   logic [207:0] rsp_data_ff;

   logic [2:0]  op_ff;
   logic [11:0] f_ff;
   logic signed [47:0] px_ff, py_ff, nx_ff, ny_ff;
   logic [34:0] bw_ff, bh_ff;
   logic [38:0] zw_ff, zh_ff, nzw_ff, nzh_ff;

   // shared bit-serial unit
   logic [UW-1:0] uq_ff, ur_ff;
   logic [39:0]   ub_ff;
   logic [vvzp_pkg::CNT_W-1:0] ucnt_ff;
   logic          udiv_ff;
   logic          u_start, u_div;
   logic [vvzp_pkg::CNT_W-1:0] u_n;
   logic [UW-1:0] u_a;
   logic [39:0]   u_b;
   logic [UW-1:0] ush, uop;
   logic [UW:0]   usum;

   // config derived
   logic [13:0] vid_w, vid_h, win_w, win_h;
   logic        no_vid, wider, div_width;
   logic [27:0] prod_vh, prod_wu;
   logic [20:0] ww_half, wh_half;
   logic [21:0] ww, wh;

   logic [11:0] f_req;
   logic [38:0] zh_res;
   logic [55:0] quo;

   // zoom about point helpers
   logic signed [47:0] edge_x, edge_y, rel_in_x, rel_in_y;
   logic [38:0] clip_x, clip_y;
   logic [16:0] rel;
   logic signed [39:0] d_x, d_y, d_cur;
   logic [38:0] d_abs;
   logic signed [47:0] shift_v, t_v, dh_v;

   // clamp helpers
   logic signed [47:0] mx, my, cl_x, cl_y;

   // output helpers
   logic signed [47:0] vx, vy;

   function automatic logic [13:0] clip_dim(input logic [13:0] v, input logic zero_one);
      logic [13:0] r;
      r = (v > vvzp_pkg::MAX_DIM) ? vvzp_pkg::MAX_DIM : v;
      if (zero_one && v == 14'd0) r = 14'd1;
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [47:0] v);
      logic [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF)       r = 32'h7FFF_FFFF;
      else if (v < -48'sh0000_8000_0000) r = 32'h8000_0000;
      else                               r = v[31:0];
      return r;
   endfunction

   function automatic logic [30:0] sat_size(input logic [38:0] v);
      return (v > 39'h00_7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
   endfunction

   function automatic logic signed [47:0] clamp_axis(input logic signed [47:0] p,
                                                     input logic signed [47:0] m);
      logic signed [47:0] r;
      r = p;
      if (p > m)  r = m;
      if (p < -m) r = -m;
      return r;
   endfunction

   function automatic logic signed [47:0] half_over(input logic [38:0] z,
                                                    input logic [21:0] w);
      logic signed [47:0] d;
      d = $signed({9'd0, z}) - $signed({26'd0, w});
      return (d > 48'sd0) ? (d >>> 1) : 48'sd0;
   endfunction

   function automatic logic signed [47:0] edge_of(input logic [20:0] half,
                                                  input logic [38:0] z,
                                                  input logic [31:0] pan);
      return $signed({27'd0, half}) - $signed({10'd0, z[38:1]})
             + $signed({{16{pan[31]}}, pan});
   endfunction

   function automatic logic [38:0] clip_rel(input logic signed [47:0] v,
                                            input logic [38:0] z);
      logic [38:0] r;
      if (v < 48'sd0)                    r = 39'd0;
      else if (v > $signed({9'd0, z}))   r = z;
      else                               r = v[38:0];
      return r;
   endfunction

   always_comb begin
      vid_w   = clip_dim(video_width_ff, 1'b0);
      vid_h   = clip_dim(video_height_ff, 1'b0);
      win_w   = clip_dim(window_width_ff, 1'b1);
      win_h   = clip_dim(window_height_ff, 1'b1);
      no_vid  = (vid_w == 14'd0) || (vid_h == 14'd0);
      prod_vh = vid_w * win_h;
      prod_wu = win_w * vid_h;
      wider   = prod_vh > prod_wu;
      div_width = (scale_mode_ff == vvzp_pkg::MODE_FILL) ? wider : !wider;
      ww      = {win_w, 8'd0};
      wh      = {win_h, 8'd0};
      ww_half = {win_w, 7'd0};
      wh_half = {win_h, 7'd0};

      f_req = (req_tdata[15:0] < 16'(vvzp_pkg::ZOOM_LO)) ? vvzp_pkg::ZOOM_LO :
              (req_tdata[15:0] > 16'(vvzp_pkg::ZOOM_HI)) ? vvzp_pkg::ZOOM_HI :
              req_tdata[11:0];

      zh_res = ur_ff[46:8];
      quo    = uq_ff[55:0];

      edge_x   = edge_of(ww_half, zw_ff, pan_x_ff);
      edge_y   = edge_of(wh_half, zh_ff, pan_y_ff);
      rel_in_x = px_ff - edge_x;
      rel_in_y = py_ff - edge_y;
      clip_x   = clip_rel(rel_in_x, zw_ff);
      clip_y   = clip_rel(rel_in_y, zh_ff);

      d_x   = $signed({1'b0, nzw_ff}) - $signed({1'b0, zw_ff});
      d_y   = $signed({1'b0, nzh_ff}) - $signed({1'b0, zh_ff});
      d_cur = (state_ff == vvzp_pkg::ST_ZA_MY || state_ff == vvzp_pkg::ST_ZA_SY) ? d_y : d_x;
      d_abs = d_cur[39] ? 39'(-d_cur) : d_cur[38:0];
      // divide by zero size leaves rel at zero
      rel   = (((state_ff == vvzp_pkg::ST_ZA_MY) ? zh_ff : zw_ff) == 39'd0) ? 17'd0 : quo[16:0];
      t_v   = $signed({8'd0, ur_ff[55:16]});
      dh_v  = (48'(d_cur) + (d_cur[39] ? 48'sd1 : 48'sd0)) >>> 1;
      shift_v = dh_v - (d_cur[39] ? -t_v : t_v);

      mx   = half_over(zw_ff, ww);
      my   = half_over(zh_ff, wh);
      cl_x = clamp_axis(nx_ff, mx);
      cl_y = clamp_axis(ny_ff, my);

      vx = edge_of(ww_half, zw_ff, pan_x_ff);
      vy = edge_of(wh_half, zh_res, pan_y_ff);

      // unit datapath: shift-add multiply or restoring divide, msb first
      ush  = udiv_ff ? {ur_ff[UW-2:0], uq_ff[UW-1]} : {ur_ff[UW-2:0], 1'b0};
      uop  = udiv_ff ? ~{24'd0, ub_ff} : (uq_ff[UW-1] ? {24'd0, ub_ff} : '0);
      usum = {1'b0, ush} + {1'b0, uop} + {{UW{1'b0}}, udiv_ff};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      u_start  = 1'b0;
      u_div    = 1'b0;
      u_n      = 6'd12;
      u_a      = {zoom_ff, 52'd0};
      u_b      = {5'd0, bw_ff};
      unique case (state_ff)
         vvzp_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = vvzp_pkg::ST_BASE;
         end
         vvzp_pkg::ST_BASE: begin
            if (no_vid || scale_mode_ff == vvzp_pkg::MODE_STRETCH) begin
               state_in = vvzp_pkg::ST_BASE_WR;
            end else begin
               u_start  = 1'b1;
               u_div    = 1'b1;
               u_n      = 6'(vvzp_pkg::DIV_BITS);
               u_a      = div_width ? {20'd0, prod_vh, 8'd0, 8'd0}
                                    : {20'd0, prod_wu, 8'd0, 8'd0};
               u_b      = div_width ? {26'd0, vid_h} : {26'd0, vid_w};
               ret_in   = vvzp_pkg::ST_BASE_WR;
               state_in = vvzp_pkg::ST_RUN;
            end
         end
         vvzp_pkg::ST_BASE_WR: state_in = vvzp_pkg::ST_OPS;
         vvzp_pkg::ST_OPS: begin
            case (op_ff)
               vvzp_pkg::OP_SET_ZOOM:
                  state_in = (f_ff != zoom_ff) ? vvzp_pkg::ST_CL_MW : vvzp_pkg::ST_OUT_MW;
               vvzp_pkg::OP_ZOOM_POINT: begin
                  if (f_ff == zoom_ff || no_vid) begin
                     state_in = vvzp_pkg::ST_OUT_MW;
                  end else begin
                     u_start  = 1'b1;
                     ret_in   = vvzp_pkg::ST_ZA_OH;
                     state_in = vvzp_pkg::ST_RUN;
                  end
               end
               vvzp_pkg::OP_SET_PAN: state_in = vvzp_pkg::ST_CL_MW;
               default: state_in = vvzp_pkg::ST_OUT_MW;
            endcase
         end
         vvzp_pkg::ST_RUN: begin
            if (ucnt_ff == 6'd1) state_in = ret_ff;
         end
         vvzp_pkg::ST_CL_MW: begin
            if (no_vid || zoom_ff <= vvzp_pkg::ZOOM_ONE) begin
               state_in = vvzp_pkg::ST_OUT_MW;
            end else begin
               u_start  = 1'b1;
               ret_in   = vvzp_pkg::ST_CL_MH;
               state_in = vvzp_pkg::ST_RUN;
            end
         end
         vvzp_pkg::ST_CL_MH: begin
            u_start  = 1'b1;
            u_b      = {5'd0, bh_ff};
            ret_in   = vvzp_pkg::ST_CL_ZH;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_CL_ZH: state_in = vvzp_pkg::ST_CL_DO;
         vvzp_pkg::ST_CL_DO: state_in = vvzp_pkg::ST_OUT_MW;
         vvzp_pkg::ST_ZA_OH: begin
            u_start  = 1'b1;
            u_b      = {5'd0, bh_ff};
            ret_in   = vvzp_pkg::ST_ZA_NW;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_ZA_NW: begin
            u_start  = 1'b1;
            u_a      = {f_ff, 52'd0};
            ret_in   = vvzp_pkg::ST_ZA_NH;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_ZA_NH: begin
            u_start  = 1'b1;
            u_a      = {f_ff, 52'd0};
            u_b      = {5'd0, bh_ff};
            ret_in   = vvzp_pkg::ST_ZA_RX;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_ZA_RX: begin
            u_start  = 1'b1;
            u_div    = 1'b1;
            u_n      = 6'(vvzp_pkg::DIV_BITS);
            u_a      = {1'b0, clip_x, 16'd0, 8'd0};
            u_b      = {1'b0, zw_ff};
            ret_in   = vvzp_pkg::ST_ZA_MX;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_ZA_MX, vvzp_pkg::ST_ZA_MY: begin
            u_start  = 1'b1;
            u_n      = 6'd17;
            u_a      = {rel, 47'd0};
            u_b      = {1'b0, d_abs};
            ret_in   = (state_ff == vvzp_pkg::ST_ZA_MX) ? vvzp_pkg::ST_ZA_SX
                                                        : vvzp_pkg::ST_ZA_SY;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_ZA_SX: begin
            u_start  = 1'b1;
            u_div    = 1'b1;
            u_n      = 6'(vvzp_pkg::DIV_BITS);
            u_a      = {1'b0, clip_y, 16'd0, 8'd0};
            u_b      = {1'b0, zh_ff};
            ret_in   = vvzp_pkg::ST_ZA_MY;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_ZA_SY: state_in = vvzp_pkg::ST_CL_DO;
         vvzp_pkg::ST_OUT_MW: begin
            if (no_vid) begin
               state_in = vvzp_pkg::ST_OUT_FIN;
            end else begin
               u_start  = 1'b1;
               ret_in   = vvzp_pkg::ST_OUT_MH;
               state_in = vvzp_pkg::ST_RUN;
            end
         end
         vvzp_pkg::ST_OUT_MH: begin
            u_start  = 1'b1;
            u_b      = {5'd0, bh_ff};
            ret_in   = vvzp_pkg::ST_OUT_FIN;
            state_in = vvzp_pkg::ST_RUN;
         end
         vvzp_pkg::ST_OUT_FIN: begin
            if (!rsp_valid_ff || rsp_tready) state_in = vvzp_pkg::ST_IDLE;
         end
         default: state_in = vvzp_pkg::ST_IDLE;
      endcase
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == vvzp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= vvzp_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         scale_mode_ff    <= vvzp_pkg::MODE_STRETCH;
         video_width_ff   <= 14'd0;
         video_height_ff  <= 14'd0;
         window_width_ff  <= 14'd640;
         window_height_ff <= 14'd480;
         zoom_ff          <= vvzp_pkg::ZOOM_ONE;
         pan_x_ff         <= 32'd0;
         pan_y_ff         <= 32'd0;
      end else begin
         state_ff <= state_in;
         // a new result may load in the same cycle the old one leaves
         if (state_ff == vvzp_pkg::ST_OUT_FIN && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               vvzp_pkg::REG_SCALE_MODE: begin
                  scale_mode_ff <= csr_data[1:0];
                  pan_x_ff      <= 32'd0;
                  pan_y_ff      <= 32'd0;
               end
               vvzp_pkg::REG_VIDEO_WIDTH:   video_width_ff   <= csr_data;
               vvzp_pkg::REG_VIDEO_HEIGHT:  video_height_ff  <= csr_data;
               vvzp_pkg::REG_WINDOW_WIDTH:  window_width_ff  <= csr_data;
               vvzp_pkg::REG_WINDOW_HEIGHT: window_height_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            vvzp_pkg::ST_OPS: begin
               case (op_ff)
                  vvzp_pkg::OP_SET_ZOOM: zoom_ff <= f_ff;
                  vvzp_pkg::OP_ZOOM_POINT: begin
                     if (f_ff != zoom_ff && no_vid) begin
                        zoom_ff  <= f_ff;
                        pan_x_ff <= 32'd0;
                        pan_y_ff <= 32'd0;
                     end
                  end
                  vvzp_pkg::OP_RESET_VIEW: begin
                     zoom_ff  <= vvzp_pkg::ZOOM_ONE;
                     pan_x_ff <= 32'd0;
                     pan_y_ff <= 32'd0;
                  end
                  default: ;
               endcase
            end
            vvzp_pkg::ST_CL_MW: begin
               if (no_vid || zoom_ff <= vvzp_pkg::ZOOM_ONE) begin
                  pan_x_ff <= 32'd0;
                  pan_y_ff <= 32'd0;
               end
            end
            vvzp_pkg::ST_CL_DO: begin
               if (zoom_ff <= vvzp_pkg::ZOOM_ONE) begin
                  pan_x_ff <= 32'd0;
                  pan_y_ff <= 32'd0;
               end else begin
                  pan_x_ff <= sat32(cl_x);
                  pan_y_ff <= sat32(cl_y);
               end
            end
            vvzp_pkg::ST_ZA_SY: zoom_ff <= f_ff;
            default: ;
         endcase
      end
   end

   // payload and unit registers
   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      if (state_ff == vvzp_pkg::ST_IDLE && req_tvalid) begin
         op_ff <= req_tuser;
         f_ff  <= f_req;
         px_ff <= {{23{req_tdata[40]}}, req_tdata[40:16]};
         py_ff <= {{23{req_tdata[65]}}, req_tdata[65:41]};
      end
      if (u_start) begin
         uq_ff   <= u_a;
         ur_ff   <= '0;
         ub_ff   <= u_b;
         ucnt_ff <= u_n;
         udiv_ff <= u_div;
      end else if (state_ff == vvzp_pkg::ST_RUN) begin
         ucnt_ff <= ucnt_ff - 6'd1;
         if (udiv_ff) begin
            ur_ff <= usum[UW] ? usum[UW-1:0] : ush;
            uq_ff <= {uq_ff[UW-2:0], usum[UW]};
         end else begin
            ur_ff <= usum[UW-1:0];
            uq_ff <= {uq_ff[UW-2:0], 1'b0};
         end
      end
      case (state_ff)
         vvzp_pkg::ST_BASE_WR: begin
            bw_ff <= (!no_vid && scale_mode_ff != vvzp_pkg::MODE_STRETCH && div_width)
                     ? quo[34:0] : {13'd0, win_w, 8'd0};
            bh_ff <= (!no_vid && scale_mode_ff != vvzp_pkg::MODE_STRETCH && !div_width)
                     ? quo[34:0] : {13'd0, win_h, 8'd0};
         end
         vvzp_pkg::ST_OPS: begin
            if (op_ff == vvzp_pkg::OP_SET_PAN) begin
               nx_ff <= px_ff;
               ny_ff <= py_ff;
            end else begin
               nx_ff <= {{16{pan_x_ff[31]}}, pan_x_ff};
               ny_ff <= {{16{pan_y_ff[31]}}, pan_y_ff};
            end
         end
         vvzp_pkg::ST_CL_MH, vvzp_pkg::ST_ZA_OH, vvzp_pkg::ST_OUT_MH: zw_ff <= zh_res;
         vvzp_pkg::ST_CL_ZH, vvzp_pkg::ST_ZA_NW: zh_ff <= zh_res;
         vvzp_pkg::ST_ZA_NH: nzw_ff <= zh_res;
         vvzp_pkg::ST_ZA_RX: nzh_ff <= zh_res;
         vvzp_pkg::ST_ZA_SX: nx_ff <= $signed({{16{pan_x_ff[31]}}, pan_x_ff}) + shift_v;
         vvzp_pkg::ST_ZA_SY: begin
            ny_ff <= $signed({{16{pan_y_ff[31]}}, pan_y_ff}) + shift_v;
            zw_ff <= nzw_ff;
            zh_ff <= nzh_ff;
         end
         vvzp_pkg::ST_OUT_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff[207:202] <= 6'd0;
               rsp_data_ff[137:126] <= zoom_ff;
               rsp_data_ff[169:138] <= pan_x_ff;
               rsp_data_ff[201:170] <= pan_y_ff;
               if (no_vid) begin
                  rsp_data_ff[31:0]   <= 32'd0;
                  rsp_data_ff[63:32]  <= 32'd0;
                  rsp_data_ff[94:64]  <= {9'd0, ww};
                  rsp_data_ff[125:95] <= {9'd0, wh};
               end else begin
                  rsp_data_ff[31:0]   <= sat32(vx);
                  rsp_data_ff[63:32]  <= sat32(vy);
                  rsp_data_ff[94:64]  <= sat_size(zw_ff);
                  rsp_data_ff[125:95] <= sat_size(zh_res);
               end
            end
         end
         default: ;
      endcase
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for video_viewport_zoom_pan: random zoom, pan and query
// requests under several window, video and scale-mode settings, each response
// checked field by field against a behavioral viewport predictor.
// ----------------------------------------------------------------------------
module tb;

   localparam int N_RANDOM  = 1950;
   localparam int CYCLE_CAP = 2000000;

   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        zoom;
      logic signed [24:0] px;
      logic signed [24:0] py;
   } event_type;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [30:0]        vw;
      logic [30:0]        vh;
      logic [11:0]        zm;
      logic signed [31:0] pnx;
      logic signed [31:0] pny;
   } view_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [13:0]  csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [2:0]   req_tuser = '0;
   logic [71:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;

   video_viewport_zoom_pan u_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   longint m_mode, m_vw, m_vh, m_ww, m_wh, m_zoom, m_panx, m_pany;

   event_type pending_events[$];
   view_type  expected_views[$];
   int     errors = 0;
   int     checked = 0;
   longint cycles = 0;
   bit     rx_hold = 1'b0;
   int     rx_hold_cycles = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat32(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint win_w();
      return clip(m_ww, 1, 8192);
   endfunction

   function automatic longint win_h();
      return clip(m_wh, 1, 8192);
   endfunction

   function automatic bit base_size(output longint bw, output longint bh);
      longint v, u, w, h;
      bit wider;
      v = clip(m_vw, 0, 8192);
      u = clip(m_vh, 0, 8192);
      w = win_w();
      h = win_h();
      bw = 0;
      bh = 0;
      if (v == 0 || u == 0) return 1'b0;
      wider = v * h > w * u;
      if (m_mode == vvzp_pkg::MODE_STRETCH) begin
         bw = w <<< vvzp_pkg::FRAC_BITS;
         bh = h <<< vvzp_pkg::FRAC_BITS;
      end else if (m_mode == vvzp_pkg::MODE_FILL ? wider : !wider) begin
         bh = h <<< vvzp_pkg::FRAC_BITS;
         bw = ((h * v) <<< vvzp_pkg::FRAC_BITS) / u;
      end else begin
         bw = w <<< vvzp_pkg::FRAC_BITS;
         bh = ((w * u) <<< vvzp_pkg::FRAC_BITS) / v;
      end
      return 1'b1;
   endfunction

   function automatic void place_view(output longint r[4]);
      longint bw, bh, ww, wh;
      ww = win_w() <<< vvzp_pkg::FRAC_BITS;
      wh = win_h() <<< vvzp_pkg::FRAC_BITS;
      if (!base_size(bw, bh)) begin
         r = '{0, 0, ww, wh};
         return;
      end
      r[2] = bw * m_zoom / 256;
      r[3] = bh * m_zoom / 256;
      r[0] = ww / 2 - r[2] / 2 + m_panx;
      r[1] = wh / 2 - r[3] / 2 + m_pany;
   endfunction

   function automatic void limit_pan(longint px, longint py);
      longint bw, bh, mx, my;
      if (!base_size(bw, bh) || m_zoom <= 256) begin
         m_panx = 0;
         m_pany = 0;
         return;
      end
      mx = bw * m_zoom / 256 - (win_w() <<< vvzp_pkg::FRAC_BITS);
      my = bh * m_zoom / 256 - (win_h() <<< vvzp_pkg::FRAC_BITS);
      mx = mx > 0 ? mx / 2 : 0;
      my = my > 0 ? my / 2 : 0;
      m_panx = sat32(clip(px, -mx, mx));
      m_pany = sat32(clip(py, -my, my));
   endfunction

   function automatic longint anchor_shift(longint e, longint sz, longint pt, longint nsz);
      longint rel, d;
      rel = 0;
      d = nsz - sz;
      if (sz > 0) rel = clip(pt - e, 0, sz) * 65536 / sz;
      return -(d * rel / 65536) + d / 2;
   endfunction

   function automatic view_type apply_event(event_type ev);
      longint f, px, py, bw, bh, nx, ny;
      longint r[4];
      view_type res;
      f = clip(longint'(ev.zoom), vvzp_pkg::ZOOM_LO, vvzp_pkg::ZOOM_HI);
      px = longint'(ev.px);
      py = longint'(ev.py);
      case (ev.op)
         vvzp_pkg::OP_SET_ZOOM: begin
            if (f != m_zoom) begin
               m_zoom = f;
               limit_pan(m_panx, m_pany);
            end
         end
         vvzp_pkg::OP_ZOOM_POINT: begin
            if (f != m_zoom) begin
               if (base_size(bw, bh)) begin
                  place_view(r);
                  nx = m_panx + anchor_shift(r[0], r[2], px, bw * f / 256);
                  ny = m_pany + anchor_shift(r[1], r[3], py, bh * f / 256);
                  m_zoom = f;
                  limit_pan(nx, ny);
               end else begin
                  m_zoom = f;
                  m_panx = 0;
                  m_pany = 0;
               end
            end
         end
         vvzp_pkg::OP_SET_PAN: limit_pan(px, py);
         vvzp_pkg::OP_RESET_VIEW: begin
            m_zoom = 256;
            m_panx = 0;
            m_pany = 0;
         end
         default: ;
      endcase
      place_view(r);
      res.vx = 32'(sat32(r[0]));
      res.vy = 32'(sat32(r[1]));
      res.vw = 31'(clip(r[2], 0, 64'sd2147483647));
      res.vh = 31'(clip(r[3], 0, 64'sd2147483647));
      res.zm = 12'(m_zoom);
      res.pnx = 32'(m_panx);
      res.pny = 32'(m_pany);
      return res;
   endfunction

   // driver
   int tx_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
      end else if (tx_gap > 0) begin
         req_tvalid <= 1'b0;
         tx_gap <= tx_gap - 1;
      end else if (pending_events.size() > 0) begin
         event_type ev;
         ev = pending_events.pop_front();
         expected_views.push_back(apply_event(ev));
         req_tvalid <= 1'b1;
         req_tuser <= ev.op;
         req_tdata <= {6'd0, ev.py, ev.px, ev.zoom};
         tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // monitor
   int rx_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            view_type got, want;
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[94:64], rsp_tdata[125:95],
                   rsp_tdata[137:126], rsp_tdata[169:138], rsp_tdata[201:170]};
            if (expected_views.size() == 0) begin
               $display("%t unexpected response %h", $time, got);
               errors++;
            end else begin
               want = expected_views.pop_front();
               checked++;
               if (got.vx !== want.vx) begin
                  $display("%t view_x exp %0d got %0d", $time, want.vx, got.vx); errors++;
               end
               if (got.vy !== want.vy) begin
                  $display("%t view_y exp %0d got %0d", $time, want.vy, got.vy); errors++;
               end
               if (got.vw !== want.vw) begin
                  $display("%t view_w exp %0d got %0d", $time, want.vw, got.vw); errors++;
               end
               if (got.vh !== want.vh) begin
                  $display("%t view_h exp %0d got %0d", $time, want.vh, got.vh); errors++;
               end
               if (got.zm !== want.zm) begin
                  $display("%t zoom_now exp %0d got %0d", $time, want.zm, got.zm); errors++;
               end
               if (got.pnx !== want.pnx) begin
                  $display("%t pan_now_x exp %0d got %0d", $time, want.pnx, got.pnx); errors++;
               end
               if (got.pny !== want.pny) begin
                  $display("%t pan_now_y exp %0d got %0d", $time, want.pny, got.pny); errors++;
               end
            end
         end
         if (rx_hold) begin
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rsp_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
         end else if (!rsp_tready || rsp_tvalid) begin
            rsp_tready <= 1'b1;
            rx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         end
      end
   end

   // long receiver stall, counted here
   always @(posedge clock) begin
      if (rx_hold_cycles > 0) begin
         rx_hold <= 1'b1;
         rx_hold_cycles <= rx_hold_cycles - 1;
      end else begin
         rx_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("video_viewport_zoom_pan regression: fail");
         $finish;
      end
   end

   task automatic drain();
      while (pending_events.size() > 0 || expected_views.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [13:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         vvzp_pkg::REG_SCALE_MODE: begin
            m_mode = longint'(val & 14'd3);
            m_panx = 0;
            m_pany = 0;
         end
         vvzp_pkg::REG_VIDEO_WIDTH:   m_vw = longint'(val);
         vvzp_pkg::REG_VIDEO_HEIGHT:  m_vh = longint'(val);
         vvzp_pkg::REG_WINDOW_WIDTH:  m_ww = longint'(val);
         vvzp_pkg::REG_WINDOW_HEIGHT: m_wh = longint'(val);
         default: ;
      endcase
   endtask

   function automatic event_type random_event();
      event_type ev;
      int k;
      k = $urandom_range(0, 9);
      ev.op = (k < 3) ? vvzp_pkg::OP_ZOOM_POINT : (k < 5) ? vvzp_pkg::OP_SET_PAN :
              (k < 7) ? vvzp_pkg::OP_SET_ZOOM : (k < 8) ? vvzp_pkg::OP_RESET_VIEW :
              3'($urandom_range(4, 7));
      ev.zoom = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(100, 2700));
      if ($urandom_range(0, 2) == 0) begin
         ev.px = 25'($urandom);
         ev.py = 25'($urandom);
      end else begin
         ev.px = 25'($urandom_range(0, 600000)) - 25'sd100000;
         ev.py = 25'($urandom_range(0, 600000)) - 25'sd100000;
      end
      return ev;
   endfunction

   function automatic logic [13:0] random_dim();
      int k;
      k = $urandom_range(0, 9);
      return (k == 0) ? 14'($urandom) : (k == 1) ? 14'd8192 : 14'($urandom_range(1, 1920));
   endfunction

   initial begin
      event_type ev;
      int n;
      m_mode = 0; m_vw = 0; m_vh = 0; m_ww = 640; m_wh = 480;
      m_zoom = 256; m_panx = 0; m_pany = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every op with no video first, then field extremes
      for (int op = 0; op < 8; op++) begin
         ev = '{3'(op), 16'd2560, 25'sd1000, -25'sd1000};
         pending_events.push_back(ev);
      end
      drain();
      write_reg(vvzp_pkg::REG_VIDEO_WIDTH, 14'd1920);
      write_reg(vvzp_pkg::REG_VIDEO_HEIGHT, 14'd1080);
      write_reg(vvzp_pkg::REG_SCALE_MODE, 14'd2);
      pending_events.push_back('{vvzp_pkg::OP_SET_ZOOM, 16'd0, 25'sd0, 25'sd0});
      pending_events.push_back('{vvzp_pkg::OP_SET_ZOOM, 16'hFFFF, 25'sd0, 25'sd0});
      pending_events.push_back('{vvzp_pkg::OP_SET_ZOOM, 16'hFFFF, 25'sd0, 25'sd0});
      pending_events.push_back('{vvzp_pkg::OP_SET_PAN, 16'd0, 25'h0FFFFFF, 25'h1000000});
      pending_events.push_back('{vvzp_pkg::OP_ZOOM_POINT, 16'd300, 25'h1000000, 25'h0FFFFFF});
      pending_events.push_back('{vvzp_pkg::OP_ZOOM_POINT, 16'd300, 25'sd0, 25'sd0});
      pending_events.push_back('{vvzp_pkg::OP_ZOOM_POINT, 16'd1000, 25'sd80000, 25'sd60000});
      pending_events.push_back('{vvzp_pkg::OP_SET_ZOOM, 16'd256, 25'sd0, 25'sd0});
      pending_events.push_back('{vvzp_pkg::OP_RESET_VIEW, 16'd0, 25'sd0, 25'sd0});
      pending_events.push_back('{3'd7, 16'd0, 25'sd0, 25'sd0});
      drain();
      write_reg(vvzp_pkg::REG_SCALE_MODE, 14'd3);
      write_reg(vvzp_pkg::REG_WINDOW_WIDTH, 14'd0);
      write_reg(vvzp_pkg::REG_WINDOW_HEIGHT, 14'h3FFF);
      pending_events.push_back('{vvzp_pkg::OP_ZOOM_POINT, 16'd2560, 25'sd5, 25'sd5});
      pending_events.push_back('{vvzp_pkg::OP_SET_PAN, 16'd0, -25'sd7000000, 25'sd7000000});
      drain();

      // random phases under varied settings
      for (int phase = 0; phase < 13; phase++) begin
         write_reg(vvzp_pkg::REG_SCALE_MODE, 14'($urandom_range(0, 3)));
         write_reg(vvzp_pkg::REG_VIDEO_WIDTH, (phase == 3) ? 14'd0 : random_dim());
         write_reg(vvzp_pkg::REG_VIDEO_HEIGHT, random_dim());
         write_reg(vvzp_pkg::REG_WINDOW_WIDTH, (phase == 5) ? 14'd8192 : random_dim());
         write_reg(vvzp_pkg::REG_WINDOW_HEIGHT, (phase == 5) ? 14'd1 : random_dim());
         if (phase == 2) rx_hold_cycles = 3000;
         for (n = 0; n < N_RANDOM / 13; n++) begin
            pending_events.push_back(random_event());
            if (n == 75) begin
               while (pending_events.size() > 0 || expected_views.size() > 0)
                  @(posedge clock);
            end
         end
         drain();
      end

      $display("covered %0d checked responses over 13 random register settings", checked);
      $display("all opcodes, zoom clamp edges, no-video and odd sizes included");
      if (errors == 0) begin
         $display("video_viewport_zoom_pan regression: pass");
      end else begin
         $display("video_viewport_zoom_pan regression: fail");
      end
      $finish;
   end
endmodule
